/* rtl/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

	// Field widths of the request and response transactions.
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;

	// Default store depth and capacity register reset value.
	localparam int ENTRIES_DEFAULT = 16;
	localparam int CAPACITY_RESET = 16;

	// Operation codes carried on func.
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_FINISH
	} lkv_state_t;

	// Control handed to the shared entry unit for the entry being evaluated.
	typedef struct packed {
		logic entry_valid;
		logic have_old;
		logic insert;
		logic put;
		logic is_target;
	} lkv_eval_ctl_t;

endpackage

/* rtl/lkv_ram.sv */
`timescale 1ns / 1ps

module lkv_ram #(
	parameter int DEPTH = lkv_pkg::ENTRIES_DEFAULT,
	parameter int AW = 4,
	parameter int DW = 67
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/lkv_entry_unit.sv */
`timescale 1ns / 1ps

module lkv_entry_unit #(
	parameter int AW = 4
) (
	input  lkv_pkg::lkv_eval_ctl_t        ctl,
	input  logic [lkv_pkg::KEY_W-1:0]     ent_key,
	input  logic [lkv_pkg::VAL_W-1:0]     ent_val,
	input  logic [AW-1:0]                 ent_age,
	input  logic [lkv_pkg::KEY_W-1:0]     req_key,
	input  logic [lkv_pkg::VAL_W-1:0]     req_val,
	input  logic [AW-1:0]                 best_age,
	input  logic [AW-1:0]                 ref_age,
	output logic                          match,
	output logic                          older,
	output logic [lkv_pkg::KEY_W-1:0]     wr_key,
	output logic [lkv_pkg::VAL_W-1:0]     wr_val,
	output logic [AW-1:0]                 wr_age
);

	// Lookup compare and least recent search for the scan pass.
	always_comb begin
		match = ctl.entry_valid && (ent_key == req_key);
		older = ctl.entry_valid && (!ctl.have_old || (ent_age >= best_age));
	end

	// Rewritten entry for the update pass. The target becomes most recent; other
	// valid entries age by one on an insert, or when younger than the touched one.
	always_comb begin
		wr_key = ent_key;
		wr_val = ent_val;
		wr_age = ent_age;
		if (ctl.is_target) begin
			wr_key = req_key;
			wr_age = '0;
			if (ctl.insert || ctl.put) begin
				wr_val = req_val;
			end
		end else if (ctl.entry_valid && (ctl.insert || (ent_age < ref_age))) begin
			wr_age = ent_age + AW'(1);
		end
	end

endmodule

/* rtl/lru_key_value_cache_unit.sv */
`timescale 1ns / 1ps
// A request is taken in IDLE; a scan pass then reads every entry, DECIDE plans the
// update, and for a get hit or any put an update pass rewrites every entry; a get miss
// skips the update pass. The response is loaded in FINISH. The next request is taken
// only after the cache returns to IDLE, since the scan and update passes go one entry a
// cycle through the entry memory and shared entry unit; a response still waiting adds stalls.
// Reset: the store is empty, capacity is 16 and no response is pending.

module lru_key_value_cache_unit #(
	parameter int ENTRIES = lkv_pkg::ENTRIES_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          func,
	input  logic [lkv_pkg::KEY_W-1:0]     key,
	input  logic [lkv_pkg::VAL_W-1:0]     value,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          hit,
	output logic [lkv_pkg::VAL_W-1:0]     read_value,
	output logic                          evicted,
	output logic [lkv_pkg::KEY_W-1:0]     evicted_key
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW = $clog2(ENTRIES + 1);
	localparam int CW = (UW > lkv_pkg::CAP_W) ? UW : lkv_pkg::CAP_W;
	localparam int KW = lkv_pkg::KEY_W;
	localparam int VW = lkv_pkg::VAL_W;
	localparam int DW = KW + VW + AW;

	lkv_pkg::lkv_state_t state_q, state_d;

	logic [UW-1:0] cnt_q, cnt_d;
	logic          rd_en, rd_en_s1;
	logic [AW-1:0] idx_s1;
	logic          ram_we;
	logic          do_decide, load_rsp;
	logic [DW-1:0] rd_data, wr_data;

	logic [lkv_pkg::CAP_W-1:0] cap_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [UW-1:0]             used_q;

	logic          func_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] value_q;

	logic          found_q, free_q, old_q;
	logic [AW-1:0] found_idx_q, free_idx_q, old_idx_q;
	logic [AW-1:0] found_age_q, old_age_q;
	logic [VW-1:0] found_val_q;
	logic [KW-1:0] old_key_q;

	logic          insert_q, put_q;
	logic [AW-1:0] target_q, ref_age_q;

	logic          res_hit_q, res_ev_q;
	logic [VW-1:0] res_rd_q;
	logic [KW-1:0] res_evkey_q;

	logic          rsp_valid_q, hit_q, evicted_q;
	logic [VW-1:0] read_value_q;
	logic [KW-1:0] evicted_key_q;

	logic [KW-1:0] ent_key, wr_key;
	logic [VW-1:0] ent_val, wr_val;
	logic [AW-1:0] ent_age, wr_age;
	logic          match, older;
	logic [CW-1:0] eff_cap;
	lkv_pkg::lkv_eval_ctl_t eval_ctl;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		req_stall = 1'b1;
		rd_en     = 1'b0;
		ram_we    = 1'b0;
		do_decide = 1'b0;
		load_rsp  = 1'b0;
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				cnt_d     = '0;
				if (req_valid) begin
					state_d = lkv_pkg::ST_SCAN;
				end
			end
			lkv_pkg::ST_SCAN: begin
				if (cnt_q == UW'(ENTRIES)) begin
					cnt_d   = '0;
					state_d = lkv_pkg::ST_DECIDE;
				end else begin
					rd_en = 1'b1;
					cnt_d = cnt_q + UW'(1);
				end
			end
			lkv_pkg::ST_DECIDE: begin
				do_decide = 1'b1;
				if (found_q || (func_q == lkv_pkg::FUNC_PUT)) begin
					state_d = lkv_pkg::ST_UPDATE;
				end else begin
					state_d = lkv_pkg::ST_FINISH;
				end
			end
			lkv_pkg::ST_UPDATE: begin
				ram_we = rd_en_s1;
				if (cnt_q == UW'(ENTRIES)) begin
					cnt_d   = '0;
					state_d = lkv_pkg::ST_FINISH;
				end else begin
					rd_en = 1'b1;
					cnt_d = cnt_q + UW'(1);
				end
			end
			lkv_pkg::ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = lkv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lkv_pkg::ST_IDLE;
			end
		endcase
	end

	// Entry counter and read pipeline tags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			cnt_q    <= cnt_d;
			rd_en_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_W'(lkv_pkg::CAPACITY_RESET);
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Capacity clamped to the range one through the store depth.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(cap_q) > CW'(ENTRIES)) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			func_q  <= func;
			key_q   <= key;
			value_q <= value;
		end
	end

	// Entry memory holding key, value and age.
	lkv_ram #(
		.DEPTH(ENTRIES),
		.AW(AW),
		.DW(DW)
	) u_ram (
		.clk(clk),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_data),
		.we(ram_we),
		.wr_addr(idx_s1),
		.wr_data(wr_data)
	);

	assign ent_key = rd_data[DW-1 -: KW];
	assign ent_val = rd_data[AW +: VW];
	assign ent_age = rd_data[AW-1:0];
	assign wr_data = {wr_key, wr_val, wr_age};

	// Shared entry unit, evaluating one entry a cycle in both passes.
	always_comb begin
		eval_ctl.entry_valid = valid_q[idx_s1];
		eval_ctl.have_old    = old_q;
		eval_ctl.insert      = insert_q;
		eval_ctl.put         = put_q;
		eval_ctl.is_target   = (idx_s1 == target_q);
	end

	lkv_entry_unit #(
		.AW(AW)
	) u_entry (
		.ctl(eval_ctl),
		.ent_key(ent_key),
		.ent_val(ent_val),
		.ent_age(ent_age),
		.req_key(key_q),
		.req_val(value_q),
		.best_age(old_age_q),
		.ref_age(ref_age_q),
		.match(match),
		.older(older),
		.wr_key(wr_key),
		.wr_val(wr_val),
		.wr_age(wr_age)
	);

	// Scan trackers: matching entry, first free entry and least recent entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
			old_q   <= 1'b0;
		end else if (req_valid && !req_stall) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
			old_q   <= 1'b0;
		end else if ((state_q == lkv_pkg::ST_SCAN) && rd_en_s1) begin
			if (match && !found_q) begin
				found_q <= 1'b1;
			end
			if (!eval_ctl.entry_valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (older) begin
				old_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == lkv_pkg::ST_SCAN) && rd_en_s1) begin
			if (match && !found_q) begin
				found_idx_q <= idx_s1;
				found_age_q <= ent_age;
				found_val_q <= ent_val;
			end
			if (!eval_ctl.entry_valid && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (older) begin
				old_idx_q <= idx_s1;
				old_age_q <= ent_age;
				old_key_q <= ent_key;
			end
		end
	end

	// Update plan: touch a hit entry, or insert into a free or evicted entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			insert_q <= 1'b0;
			put_q    <= 1'b0;
		end else if (do_decide) begin
			insert_q <= !found_q && (func_q == lkv_pkg::FUNC_PUT);
			put_q    <= (func_q == lkv_pkg::FUNC_PUT);
		end
	end

	always_ff @(posedge clk) begin
		if (do_decide) begin
			ref_age_q   <= found_age_q;
			res_hit_q   <= found_q;
			res_rd_q    <= '0;
			res_ev_q    <= 1'b0;
			res_evkey_q <= '0;
			if (found_q) begin
				target_q <= found_idx_q;
				if (func_q == lkv_pkg::FUNC_GET) begin
					res_rd_q <= found_val_q;
				end
			end else if (CW'(used_q) < eff_cap) begin
				target_q <= free_idx_q;
			end else begin
				target_q    <= old_idx_q;
				res_ev_q    <= (func_q == lkv_pkg::FUNC_PUT);
				res_evkey_q <= (func_q == lkv_pkg::FUNC_PUT) ? old_key_q : '0;
			end
		end
	end

	// Valid bits and fill count. An eviction reuses the evicted entry, so only an
	// insert into a free entry changes them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (do_decide && !found_q && (func_q == lkv_pkg::FUNC_PUT)
				&& (CW'(used_q) < eff_cap)) begin
			valid_q[free_idx_q] <= 1'b1;
			used_q              <= used_q + UW'(1);
		end
	end

	// Response register; a finished transaction waits in FINISH while it is full and stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			hit_q         <= res_hit_q;
			read_value_q  <= res_rd_q;
			evicted_q     <= res_ev_q;
			evicted_key_q <= res_evkey_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// The fill count agrees with the valid bits whenever no transaction is at work.
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lkv_pkg::ST_IDLE) |-> ($countones(valid_q) == int'(used_q)))
		else $error("fill count disagrees with valid bits");

	// An accepted request always starts the scan pass.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == lkv_pkg::ST_SCAN))
		else $error("accepted request did not start a scan");

	// The entry memory is written only during the update pass.
	a_write_update: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == lkv_pkg::ST_UPDATE))
		else $error("entry memory written outside the update pass");

	// A pending response is never overwritten before it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !load_rsp)
		else $error("pending response overwritten");

endmodule

/* test/lru_key_value_cache_unit_test.sv */
`timescale 1ns / 1ps

// One response transaction as the cache returns it.
typedef struct packed {
	logic                      hit;
	logic [lkv_pkg::VAL_W-1:0] read_value;
	logic                      evicted;
	logic [lkv_pkg::KEY_W-1:0] evicted_key;
} cache_rsp_t;

// Scoreboard: keeps its own copy of the store and queues the response that each
// accepted request should produce.
class lru_scoreboard;
	localparam int DEPTH = lkv_pkg::ENTRIES_DEFAULT;
	localparam int AGE_W = $clog2(DEPTH);

	logic [lkv_pkg::CAP_W-1:0] capacity;
	logic                      slot_valid [DEPTH];
	logic [lkv_pkg::KEY_W-1:0] slot_key [DEPTH];
	logic [lkv_pkg::VAL_W-1:0] slot_val [DEPTH];
	logic [AGE_W-1:0]          slot_age [DEPTH];
	logic [lkv_pkg::CAP_W-1:0] used;
	cache_rsp_t                rsp_q [$];
	int                        errors;

	function new();
		capacity = lkv_pkg::CAP_W'(lkv_pkg::CAPACITY_RESET);
		used = '0;
		errors = 0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_val[i] = '0;
			slot_age[i] = '0;
		end
	endfunction

	function void write_capacity(logic [lkv_pkg::CAP_W-1:0] c);
		capacity = c;
	endfunction

	// Capacity as the cache applies it: zero acts as one, large values saturate.
	function logic [lkv_pkg::CAP_W-1:0] limit();
		if (capacity == 0)
			return lkv_pkg::CAP_W'(1);
		if (capacity > DEPTH)
			return lkv_pkg::CAP_W'(DEPTH);
		return capacity;
	endfunction

	// Apply one accepted request to the shadow store and queue its response.
	function void note_request(logic f, logic [lkv_pkg::KEY_W-1:0] k,
			logic [lkv_pkg::VAL_W-1:0] v);
		int found;
		int slot;
		logic [AGE_W-1:0] best;
		logic [AGE_W-1:0] old_age;
		cache_rsp_t r;
		found = -1;
		slot = -1;
		r = '0;
		for (int i = 0; i < DEPTH; i++)
			if (found < 0 && slot_valid[i] && slot_key[i] == k)
				found = i;
		if (found >= 0) begin
			r.hit = 1'b1;
			if (f == lkv_pkg::FUNC_GET)
				r.read_value = slot_val[found];
			else
				slot_val[found] = v;
			// Entries more recent than the touched one age by one.
			old_age = slot_age[found];
			for (int i = 0; i < DEPTH; i++)
				if (slot_valid[i] && i != found && slot_age[i] < old_age)
					slot_age[i]++;
			slot_age[found] = '0;
		end else if (f == lkv_pkg::FUNC_PUT) begin
			if (used < limit())
				for (int i = 0; i < DEPTH; i++)
					if (slot < 0 && !slot_valid[i])
						slot = i;
			if (slot < 0) begin
				// Evict the oldest entry; ties go to the highest index.
				best = '0;
				for (int i = 0; i < DEPTH; i++)
					if (slot_valid[i] && (slot < 0 || slot_age[i] >= best)) begin
						slot = i;
						best = slot_age[i];
					end
				if (slot >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = slot_key[slot];
					slot_valid[slot] = 1'b0;
					if (used > 0)
						used--;
				end else begin
					slot = 0;
				end
			end
			for (int i = 0; i < DEPTH; i++)
				if (slot_valid[i])
					slot_age[i]++;
			slot_valid[slot] = 1'b1;
			slot_key[slot] = k;
			slot_val[slot] = v;
			slot_age[slot] = '0;
			if (used < DEPTH)
				used++;
		end
		rsp_q.push_back(r);
	endfunction

	// Compare one accepted response with the oldest queued one.
	function void check_response(logic h, logic [lkv_pkg::VAL_W-1:0] rv, logic ev,
			logic [lkv_pkg::KEY_W-1:0] evk);
		cache_rsp_t e;
		if (rsp_q.size() == 0) begin
			$display("%0t: unexpected response hit=%0d read_value=%h evicted=%0d key=%h",
				$time, h, rv, ev, evk);
			errors++;
			return;
		end
		e = rsp_q.pop_front();
		if (h !== e.hit) begin
			$display("%0t: hit mismatch: expected %0d, actual %0d", $time, e.hit, h);
			errors++;
		end
		if (rv !== e.read_value) begin
			$display("%0t: read_value mismatch: expected %h, actual %h",
				$time, e.read_value, rv);
			errors++;
		end
		if (ev !== e.evicted) begin
			$display("%0t: evicted mismatch: expected %0d, actual %0d", $time, e.evicted, ev);
			errors++;
		end
		if (evk !== e.evicted_key) begin
			$display("%0t: evicted_key mismatch: expected %h, actual %h",
				$time, e.evicted_key, evk);
			errors++;
		end
	endfunction
endclass

module lru_key_value_cache_unit_test;
	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [lkv_pkg::CAP_W-1:0] cfg_wdata;
	logic                      req_valid;
	logic                      req_stall;
	logic                      func;
	logic [lkv_pkg::KEY_W-1:0] key;
	logic [lkv_pkg::VAL_W-1:0] value;
	logic                      rsp_valid;
	logic                      rsp_stall;
	logic                      hit;
	logic [lkv_pkg::VAL_W-1:0] read_value;
	logic                      evicted;
	logic [lkv_pkg::KEY_W-1:0] evicted_key;

	lru_scoreboard             sb;
	bit                        req_gaps;
	bit                        rsp_gaps;
	int                        hold_cycles;
	logic [lkv_pkg::KEY_W-1:0] key_pool [24];

	lru_key_value_cache_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.evicted_key(evicted_key)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#5_000_000;
		$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end

	// Response side: random stall, with a long counted hold-off on request.
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else if (rsp_gaps && $urandom_range(0, 99) < 33) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Check every response transaction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(hit, read_value, evicted, evicted_key);
	end

	// Write the capacity register while the cache is idle.
	task automatic set_capacity(logic [lkv_pkg::CAP_W-1:0] c);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		sb.write_capacity(c);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one request and hold it until the cache takes it.
	task automatic request(logic f, logic [lkv_pkg::KEY_W-1:0] k,
			logic [lkv_pkg::VAL_W-1:0] v);
		@(negedge clk);
		while (req_gaps && $urandom_range(0, 99) < 33) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		func <= f;
		key <= k;
		value <= v;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(f, k, v);
	endtask

	// Drop valid and wait until every queued response has come back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.rsp_q.size() > 0)
			@(posedge clk);
	endtask

	// Random requests over a key pool sized so that hits and evictions both occur.
	task automatic random_phase(int count, bit pause_mid);
		int pool_n;
		logic [lkv_pkg::KEY_W-1:0] k;
		logic [lkv_pkg::VAL_W-1:0] v;
		pool_n = sb.limit() + 3;
		for (int i = 0; i < 24; i++)
			key_pool[i] = $urandom;
		if ($urandom_range(0, 1)) begin
			key_pool[0] = '0;
			key_pool[1] = '1;
		end
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(0, pool_n - 1)];
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = '1;
				default: v = lkv_pkg::VAL_W'($urandom);
			endcase
			request($urandom_range(0, 1) ? lkv_pkg::FUNC_PUT : lkv_pkg::FUNC_GET, k, v);
			if (pause_mid && n == count / 2)
				drain();
		end
	endtask

	// Main sequence.
	initial begin
		logic [lkv_pkg::CAP_W-1:0] caps [9];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		func = lkv_pkg::FUNC_GET;
		key = '0;
		value = '0;
		req_gaps = 1'b1;
		rsp_gaps = 1'b1;
		hold_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty store, field extremes, update, and eviction at capacity 3.
		set_capacity(5'd3);
		request(lkv_pkg::FUNC_GET, 32'h0000_0000, '1);
		request(lkv_pkg::FUNC_PUT, 32'h0000_0000, '0);
		request(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, '1);
		request(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, '0);
		request(lkv_pkg::FUNC_GET, 32'h0000_0000, '1);
		request(lkv_pkg::FUNC_PUT, 32'h0000_0000, 31'h5555_5555);
		request(lkv_pkg::FUNC_PUT, 32'hA5A5_A5A5, 31'h0000_0001);
		request(lkv_pkg::FUNC_PUT, 32'h1234_5678, 31'h2AAA_AAAA);
		request(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, '0);
		request(lkv_pkg::FUNC_GET, 32'h0000_0000, '0);
		request(lkv_pkg::FUNC_PUT, 32'h5A5A_5A5A, 31'h7000_0000);
		request(lkv_pkg::FUNC_GET, 32'hA5A5_A5A5, '0);
		drain();

		// Capacity zero acts as one and lies below the entries in use.
		set_capacity(5'd0);
		request(lkv_pkg::FUNC_PUT, 32'h0000_0001, 31'h0000_0011);
		request(lkv_pkg::FUNC_PUT, 32'h0000_0002, 31'h0000_0022);
		request(lkv_pkg::FUNC_GET, 32'h0000_0001, '0);
		request(lkv_pkg::FUNC_PUT, 32'h0000_0003, 31'h0000_0033);
		request(lkv_pkg::FUNC_GET, 32'h0000_0002, '0);
		drain();

		// Capacity above the store depth saturates.
		set_capacity(5'd31);
		for (int i = 0; i < 6; i++)
			request(lkv_pkg::FUNC_PUT, 32'hC000_0000 + i, lkv_pkg::VAL_W'($urandom));
		drain();

		// Random phases over a spread of capacities.
		caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd17, 5'd8, 5'd2, 5'd0};
		caps[8] = lkv_pkg::CAP_W'($urandom_range(0, 31));
		for (int p = 0; p < 9; p++) begin
			set_capacity(caps[p]);
			req_gaps = (p != 2);
			rsp_gaps = (p != 2);
			if (p == 4)
				hold_cycles = 400;
			random_phase(100, p == 3);
			drain();
		end
		req_gaps = 1'b1;
		rsp_gaps = 1'b1;

		// Let any stray response show up before the verdict.
		repeat (2 * lkv_pkg::ENTRIES_DEFAULT + 10) @(posedge clk);
		if (sb.errors == 0 && sb.rsp_q.size() == 0)
			$display("[lru_key_value_cache_unit] OK");
		else
			$display("[lru_key_value_cache_unit] ERROR");
		$finish;
	end
endmodule
